>>> design/btxk_pkg.sv
// shared types and constants for the binary trie xor-kth multiset
// no dependencies
package btxk_pkg;

  localparam int KeyBits     = 16;
  localparam int MaxNodesDef = 4096;
  localparam int CntW        = 32;
  localparam int InDataW     = 104;
  localparam int OutDataW    = 88;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_COUNT = 3'd1,
    CMD_KTH   = 3'd2,
    CMD_MIN   = 3'd3,
    CMD_MAX   = 3'd4
  } cmd_e;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRank  = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

endpackage

>>> design/btxk_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module btxk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/binary_trie_xor_kth_multiset_top.sv
// trie multiset with xor-ranked selection; one command per input beat
// kth/min/max read the near child's count at each level where it exists;
// add runs a check walk, then an update walk
// rank errors, refused adds end early; one command in work, next beat taken the cycle
// after the result register loads; the finish step waits only while a result waits
// reset: asynchronous, clears control state, node count to one and root to empty
// depends on btxk_pkg and btxk_ram
module binary_trie_xor_kth_multiset_top #(
  parameter int MAX_NODES = btxk_pkg::MaxNodesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cmd[2:0], key[18:3], amount[50:19], rank[82:51], xor_mask[98:83], zero pad
  input  logic [btxk_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // value[15:0], multiplicity[47:16], total[79:48], status[81:80], zero pad
  output logic [btxk_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int KB  = btxk_pkg::KeyBits;
  localparam int CW  = btxk_pkg::CntW;
  localparam int IW  = $clog2(MAX_NODES);
  localparam int UW  = $clog2(MAX_NODES + 1);
  localparam int LW  = $clog2(KB + 1);
  localparam int BW  = (KB > 1) ? $clog2(KB) : 1;
  localparam int NW  = 2 * IW + CW;
  localparam int SW  = ((UW > LW) ? UW : LW) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_REQ, S_DAT, S_REQ2, S_DAT2, S_NEW, S_FIN
  } state_e;

  state_e state_q;
  logic [2:0]     cmd_q;
  logic [KB-1:0]  key_q, mask_q, res_q;
  logic [CW-1:0]  amount_q, rank_q, k_q, mult_q, total_q;
  logic [1:0]     status_q;
  logic           chk_q, root_init_q;
  logic [IW-1:0]  cur_q, cf_q, cs_q;
  logic [LW-1:0]  lvl_q;
  logic [UW-1:0]  used_q;
  logic           out_valid_q;
  logic [btxk_pkg::OutDataW-1:0] out_q;

  logic           we;
  logic [IW-1:0]  waddr, raddr;
  logic [NW-1:0]  wdata, rdata, node;
  logic [CW-1:0]  ncnt;
  logic [IW-1:0]  link0, link1, lk_key, lk_f, lk_s;
  logic [BW-1:0]  bidx;
  logic           kbit, fbit;
  logic [SW-1:0]  need_sum;
  logic [KB-1:0]  low_ones;

  btxk_ram #(.Width(NW), .Depth(MAX_NODES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // root reads as empty until first written
  assign node   = (cur_q == '0 && !root_init_q && state_q == S_DAT) ? '0 : rdata;
  assign ncnt   = node[CW-1:0];
  assign link0  = node[CW +: IW];
  assign link1  = node[CW+IW +: IW];
  assign bidx   = BW'(lvl_q - LW'(1));
  assign kbit   = key_q[bidx];
  assign fbit   = mask_q[bidx];
  assign lk_key = kbit ? link1 : link0;
  assign lk_f   = fbit ? link1 : link0;
  assign lk_s   = fbit ? link0 : link1;
  assign raddr  = (state_q == S_REQ2) ? cf_q : cur_q;
  assign low_ones = ~({KB{1'b1}} << lvl_q);
  assign need_sum = SW'(used_q) + SW'(lvl_q);

  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = {link1, link0, ncnt + amount_q};
    if (state_q == S_DAT && cmd_q == btxk_pkg::CMD_ADD && !chk_q) begin
      we = 1'b1;
      if (lvl_q != '0 && lk_key == '0) begin
        if (kbit) wdata = {used_q[IW-1:0], link0, ncnt + amount_q};
        else      wdata = {link1, used_q[IW-1:0], ncnt + amount_q};
      end
    end else if (state_q == S_NEW) begin
      we    = 1'b1;
      waddr = cf_q;
      if (lvl_q == '0)  wdata = {{(2*IW){1'b0}}, amount_q};
      else if (kbit)    wdata = {used_q[IW-1:0], {IW{1'b0}}, amount_q};
      else              wdata = {{IW{1'b0}}, used_q[IW-1:0], amount_q};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      root_init_q <= 1'b0;
      total_q     <= '0;
      used_q      <= UW'(1);
      chk_q       <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_FIN) out_valid_q <= 1'b0;
      if (we && waddr == '0) begin
        total_q     <= wdata[CW-1:0];
        root_init_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q    <= s_axis_tdata[2:0];
            key_q    <= s_axis_tdata[3 +: KB];
            amount_q <= s_axis_tdata[19 +: CW];
            rank_q   <= s_axis_tdata[51 +: CW];
            mask_q   <= s_axis_tdata[83 +: KB];
            state_q  <= S_START;
          end
        end
        S_START: begin
          res_q    <= '0;
          mult_q   <= '0;
          status_q <= btxk_pkg::StOk;
          cur_q    <= '0;
          lvl_q    <= LW'(KB);
          chk_q    <= 1'b1;
          case (cmd_q)
            btxk_pkg::CMD_ADD, btxk_pkg::CMD_COUNT: state_q <= S_REQ;
            btxk_pkg::CMD_KTH, btxk_pkg::CMD_MIN, btxk_pkg::CMD_MAX: begin
              if ($signed(total_q) <= 0) begin
                status_q <= btxk_pkg::StRank;
                state_q  <= S_FIN;
              end else if (cmd_q == btxk_pkg::CMD_KTH && rank_q >= total_q) begin
                status_q <= btxk_pkg::StRank;
                state_q  <= S_FIN;
              end else begin
                if (cmd_q == btxk_pkg::CMD_KTH)      k_q <= rank_q;
                else if (cmd_q == btxk_pkg::CMD_MIN) k_q <= '0;
                else                                 k_q <= total_q - CW'(1);
                state_q <= S_REQ;
              end
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_REQ: state_q <= S_DAT;
        S_DAT: begin
          case (cmd_q)
            btxk_pkg::CMD_ADD: begin
              if (chk_q) begin
                // read-only walk: find how many nodes the add needs
                if (lvl_q != '0 && lk_key != '0) begin
                  if (lvl_q == LW'(1)) begin
                    // no node needed; restart walk for the update pass
                    chk_q   <= 1'b0;
                    cur_q   <= '0;
                    lvl_q   <= LW'(KB);
                    state_q <= S_REQ;
                  end else begin
                    cur_q   <= lk_key;
                    lvl_q   <= lvl_q - LW'(1);
                    state_q <= S_REQ;
                  end
                end else if (need_sum > SW'(MAX_NODES)) begin
                  status_q <= btxk_pkg::StFull;
                  state_q  <= S_FIN;
                end else begin
                  chk_q   <= 1'b0;
                  cur_q   <= '0;
                  lvl_q   <= LW'(KB);
                  state_q <= S_REQ;
                end
              end else if (lvl_q == '0) begin
                state_q <= S_FIN;
              end else if (lk_key == '0) begin
                cf_q    <= used_q[IW-1:0];
                used_q  <= used_q + UW'(1);
                lvl_q   <= lvl_q - LW'(1);
                state_q <= S_NEW;
              end else begin
                cur_q   <= lk_key;
                lvl_q   <= lvl_q - LW'(1);
                state_q <= S_REQ;
              end
            end
            btxk_pkg::CMD_COUNT: begin
              if (lvl_q == '0) begin
                mult_q  <= ncnt;
                state_q <= S_FIN;
              end else if (lk_key == '0) begin
                state_q <= S_FIN;
              end else begin
                cur_q   <= lk_key;
                lvl_q   <= lvl_q - LW'(1);
                state_q <= S_REQ;
              end
            end
            default: begin
              // kth walk: links of current node
              cf_q <= lk_f;
              cs_q <= lk_s;
              if (lk_f != '0) begin
                state_q <= S_REQ2;
              end else begin
                if (lk_s == '0) begin
                  res_q   <= res_q | low_ones;
                  state_q <= S_FIN;
                end else begin
                  res_q[bidx] <= 1'b1;
                  cur_q   <= lk_s;
                  lvl_q   <= lvl_q - LW'(1);
                  state_q <= (lvl_q == LW'(1)) ? S_FIN : S_REQ;
                end
              end
            end
          endcase
        end
        S_REQ2: state_q <= S_DAT2;
        S_DAT2: begin
          if ($signed(rdata[CW-1:0]) <= $signed(k_q)) begin
            k_q         <= k_q - rdata[CW-1:0];
            if (cs_q == '0) begin
              res_q   <= res_q | low_ones;
              state_q <= S_FIN;
            end else begin
              res_q[bidx] <= 1'b1;
              cur_q   <= cs_q;
              lvl_q   <= lvl_q - LW'(1);
              state_q <= (lvl_q == LW'(1)) ? S_FIN : S_REQ;
            end
          end else begin
            cur_q   <= cf_q;
            lvl_q   <= lvl_q - LW'(1);
            state_q <= (lvl_q == LW'(1)) ? S_FIN : S_REQ;
          end
        end
        S_NEW: begin
          // fresh chain below the first missing link
          if (lvl_q == '0) begin
            state_q <= S_FIN;
          end else begin
            cf_q   <= used_q[IW-1:0];
            used_q <= used_q + UW'(1);
            lvl_q  <= lvl_q - LW'(1);
          end
        end
        S_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_q       <= {6'd0, status_q, total_q, mult_q, 16'(res_q)};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
